// ===== rtl/rsdz_pkg.sv =====
package rsdz_pkg;

  localparam int SqW    = 30;
  localparam int RootW  = 15;
  localparam int NumW   = 46;
  localparam int DenW   = 22;
  localparam int QW     = 25;

  localparam logic [1:0] REG_DEAD = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;

  localparam logic [14:0] DEAD_RESET = 15'd5243;
  localparam logic [15:0] GAIN_RESET = 16'd24094;

  typedef struct packed {
    logic [7:0] stick_x;
    logic [7:0] stick_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               in_dead_zone;
  } out_word_t;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        dead;
    logic        zero;
  } flags_t;

endpackage

// ===== rtl/rsdz_sqrt_cell.sv =====
module rsdz_sqrt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vin,
  input  logic [rsdz_pkg::SqW-1:0]  rem_in,
  input  logic [rsdz_pkg::RootW-1:0] root_in,
  input  logic [3:0]                step,
  input  logic [7:0]                mx_in,
  input  logic [7:0]                my_in,
  input  rsdz_pkg::flags_t          f_in,
  output logic                      vout,
  output logic [rsdz_pkg::SqW-1:0]  rem_out,
  output logic [rsdz_pkg::RootW-1:0] root_out,
  output logic [7:0]                mx_out,
  output logic [7:0]                my_out,
  output rsdz_pkg::flags_t          f_out
);
  import rsdz_pkg::*;

  // one result bit per cell, restoring style
  logic [SqW+1:0] trial;
  logic [SqW+1:0] rem_w;
  logic [4:0]     sh;

  always_comb begin
    sh    = {step, 1'b0};
    trial = {15'd0, root_in, 2'b01} << sh;
    rem_w = {2'b0, rem_in};
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else     vout <= vin;
    mx_out <= mx_in;
    my_out <= my_in;
    f_out  <= f_in;
    if (rem_w >= trial) begin
      rem_out  <= SqW'(rem_w - trial);
      root_out <= {root_in[RootW-2:0], 1'b1};
    end else begin
      rem_out  <= rem_in;
      root_out <= {root_in[RootW-2:0], 1'b0};
    end
  end
endmodule

// ===== rtl/rsdz_div_cell.sv =====
module rsdz_div_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     vin,
  input  logic [rsdz_pkg::NumW-1:0] rem_in,
  input  logic [rsdz_pkg::QW-1:0]  q_in,
  input  logic [rsdz_pkg::DenW-1:0] den,
  input  logic [4:0]               step,
  input  logic                     neg,
  output logic                     vout,
  output logic [rsdz_pkg::NumW-1:0] rem_out,
  output logic [rsdz_pkg::QW-1:0]  q_out,
  output logic                     neg_out
);
  import rsdz_pkg::*;

  logic [NumW+QW-1:0] dsh;
  logic [NumW+QW-1:0] rw;

  always_comb begin
    dsh = {{(NumW+QW-DenW){1'b0}}, den} << step;
    rw  = {{QW{1'b0}}, rem_in};
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else     vout <= vin;
    neg_out <= neg;
    if (rw >= dsh) begin
      rem_out <= NumW'(rw - dsh);
      q_out   <= {q_in[QW-2:0], 1'b1};
    end else begin
      rem_out <= rem_in;
      q_out   <= {q_in[QW-2:0], 1'b0};
    end
  end
endmodule

// ===== rtl/radial_stick_dead_zone_unit.sv =====
// start is registered at the front stage; done is registered after the divider cells
// throughput: one word per cycle, busy is held low
// datapath: 15 square-root cells, a two-stage multiply, then 25 divider cells per axis
// done marks each result word and the receiver cannot stall it
// rst (synchronous) clears valid bits and loads the register defaults
module radial_stick_dead_zone_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rsdz_pkg::in_word_t  in_word,
  output logic                done,
  output rsdz_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rsdz_pkg::*;

  localparam int NS = RootW;
  localparam int ND = QW;

  logic [14:0] dead_radius;
  logic [15:0] rescale_gain;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_radius  <= DEAD_RESET;
      rescale_gain <= GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DEAD[0]: dead_radius  <= pwdata[14:0];
        REG_GAIN[0]: rescale_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEAD[0]: prdata = {17'd0, dead_radius};
      REG_GAIN[0]: prdata = {16'd0, rescale_gain};
      default:     prdata = '0;
    endcase
  end

  // front stage: centre and square
  logic signed [8:0] cx, cy;
  logic [7:0]        mx0, my0;
  logic [SqW-1:0]    sq0;
  logic              v0;
  flags_t            f0;

  always_comb begin
    cx = $signed({1'b0, in_word.stick_x}) - 9'sd128;
    cy = $signed({1'b0, in_word.stick_y}) - 9'sd128;
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start;
    mx0 <= cx[8] ? 8'(-cx) : cx[7:0];
    my0 <= cy[8] ? 8'(-cy) : cy[7:0];
    f0  <= '{neg_x: cx[8], neg_y: cy[8], dead: 1'b0, zero: 1'b0};
    sq0 <= SqW'({15'd0, 8'(cx[8] ? 8'(-cx) : cx[7:0])} * 8'(cx[8] ? 8'(-cx) : cx[7:0])
           + {15'd0, 8'(cy[8] ? 8'(-cy) : cy[7:0])} * 8'(cy[8] ? 8'(-cy) : cy[7:0])) << 14;
  end

  // square-root chain
  logic           sv [NS+1];
  logic [SqW-1:0] sr [NS+1];
  logic [RootW-1:0] sroot [NS+1];
  logic [7:0]     smx [NS+1];
  logic [7:0]     smy [NS+1];
  flags_t         sf [NS+1];

  assign sv[0] = v0; assign sr[0] = sq0; assign sroot[0] = '0;
  assign smx[0] = mx0; assign smy[0] = my0; assign sf[0] = f0;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    rsdz_sqrt_cell u_cell (
      .clk, .rst, .vin(sv[i]), .rem_in(sr[i]), .root_in(sroot[i]),
      .step(4'(NS-1-i)), .mx_in(smx[i]), .my_in(smy[i]), .f_in(sf[i]),
      .vout(sv[i+1]), .rem_out(sr[i+1]), .root_out(sroot[i+1]),
      .mx_out(smx[i+1]), .my_out(smy[i+1]), .f_out(sf[i+1])
    );
  end

  // multiply stages
  logic [RootW-1:0] rad;
  logic [15:0] diff;
  logic        v1, v2;
  flags_t      f1, f2;
  logic [7:0]  mx1, my1;
  logic [31:0] gd;
  logic [DenW-1:0] den1, den2;
  logic [NumW-1:0] nx, ny;

  assign rad  = sroot[NS];
  assign diff = 16'({1'b0, rad} - {1'b0, dead_radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else begin
      v1 <= sv[NS]; v2 <= v1;
    end
    f1   <= '{neg_x: sf[NS].neg_x, neg_y: sf[NS].neg_y,
              dead: (rad < dead_radius), zero: (rad == '0)};
    mx1  <= smx[NS]; my1 <= smy[NS];
    den1 <= {rad, 7'd0};
    // gain times distance past the dead radius, same word as mx1
    gd   <= {16'd0, rescale_gain} * {16'd0, diff};
    f2   <= f1; den2 <= den1;
    nx   <= {14'd0, gd} * {38'd0, mx1};
    ny   <= {14'd0, gd} * {38'd0, my1};
  end

  // divider chains
  logic          dvx [ND+1];
  logic [NumW-1:0] drx [ND+1], dry [ND+1];
  logic [QW-1:0] dqx [ND+1], dqy [ND+1];
  logic          dnx [ND+1], dny [ND+1];
  logic          dvy [ND+1];
  logic [DenW-1:0] dden [ND+1];
  flags_t        dfl [ND+1];

  assign dvx[0] = v2; assign dvy[0] = v2;
  assign drx[0] = nx; assign dry[0] = ny;
  assign dqx[0] = '0; assign dqy[0] = '0;
  assign dnx[0] = f2.neg_x; assign dny[0] = f2.neg_y;
  assign dden[0] = den2; assign dfl[0] = f2;

  for (genvar j = 0; j < ND; j++) begin : g_div
    rsdz_div_cell u_dx (
      .clk, .rst, .vin(dvx[j]), .rem_in(drx[j]), .q_in(dqx[j]), .den(dden[j]),
      .step(5'(ND-1-j)), .neg(dnx[j]),
      .vout(dvx[j+1]), .rem_out(drx[j+1]), .q_out(dqx[j+1]), .neg_out(dnx[j+1])
    );
    rsdz_div_cell u_dy (
      .clk, .rst, .vin(dvy[j]), .rem_in(dry[j]), .q_in(dqy[j]), .den(dden[j]),
      .step(5'(ND-1-j)), .neg(dny[j]),
      .vout(dvy[j+1]), .rem_out(dry[j+1]), .q_out(dqy[j+1]), .neg_out(dny[j+1])
    );
    always_ff @(posedge clk) begin
      dden[j+1] <= dden[j];
      dfl[j+1]  <= dfl[j];
    end
  end

  function automatic logic [15:0] sat(input logic [QW-1:0] q, input logic neg);
    logic [15:0] r;
    if (neg) r = (q > QW'(32768)) ? 16'h8000 : 16'(17'h10000 - 17'(q));
    else     r = (q > QW'(32767)) ? 16'h7fff : q[15:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dvx[ND] & dvy[ND];
    if (dfl[ND].dead || dfl[ND].zero) begin
      out_word <= '{out_x: '0, out_y: '0, in_dead_zone: dfl[ND].dead};
    end else begin
      out_word <= '{out_x: sat(dqx[ND], dnx[ND]), out_y: sat(dqy[ND], dny[ND]),
                    in_dead_zone: 1'b0};
    end
  end
endmodule
